FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's RTL checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: design/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// Types, operation codes and the standard DES tables as functions.
// ----------------------------------------------------------------------------
package des_pkg;

   localparam int NumRounds = 16;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_ENCRYPT = 2'd1,
      OP_DECRYPT = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef logic [47:0]                 key_type;
   typedef logic [NumRounds-1:0][47:0]  key_bank_type;

   typedef struct packed {
      logic valid;
      logic decrypt;
   } stage_ctl_type;

   localparam logic [6:0] IP_TAB [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};

   localparam logic [6:0] FP_TAB [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};

   localparam logic [5:0] E_TAB [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,
      12,13,12,13,14,15,16,17,16,17,18,19,20,21,20,21,
      22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};

   localparam logic [5:0] P_TAB [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};

   localparam logic [3:0] SBOX [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // DES position p (1 = MSB) of an n-bit word sits at bit n - p.
   function automatic logic [63:0] ip_perm(input logic [63:0] x);
      logic [63:0] r;
      for (int k = 0; k < 64; k++) begin
         r[63-k] = x[64 - int'(IP_TAB[k])];
      end
      return r;
   endfunction

   function automatic logic [63:0] fp_perm(input logic [63:0] x);
      logic [63:0] r;
      for (int k = 0; k < 64; k++) begin
         r[63-k] = x[64 - int'(FP_TAB[k])];
      end
      return r;
   endfunction

   function automatic logic [47:0] e_expand(input logic [31:0] x);
      logic [47:0] r;
      for (int k = 0; k < 48; k++) begin
         r[47-k] = x[32 - int'(E_TAB[k])];
      end
      return r;
   endfunction

   function automatic logic [31:0] p_perm(input logic [31:0] x);
      logic [31:0] r;
      for (int k = 0; k < 32; k++) begin
         r[31-k] = x[32 - int'(P_TAB[k])];
      end
      return r;
   endfunction

   // Eight S-box lookups; row from the outer bits, column from the inner four.
   function automatic logic [31:0] sbox_layer(input logic [47:0] x);
      logic [31:0] s;
      logic [5:0]  c;
      for (int i = 0; i < 8; i++) begin
         c = x[47-6*i -: 6];
         s[31-4*i -: 4] = SBOX[i][{c[5], c[0], c[4:1]}];
      end
      return s;
   endfunction

endpackage

FILE: design/des_key_store.sv
// ----------------------------------------------------------------------------
// des_key_store
// Sixteen 48-bit round key registers, written one per load item.
// ----------------------------------------------------------------------------
module des_key_store (
   input  logic                  clock,
   input  logic                  write_en,
   input  logic [3:0]            write_index,
   input  des_pkg::key_type      write_key,
   output des_pkg::key_bank_type keys
);
   import des_pkg::*;

   key_bank_type keys_ff;

   // No reset: an entry must be written before it is read; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (write_en) begin
         keys_ff[write_index] <= write_key;
      end
   end

   assign keys = keys_ff;

endmodule

FILE: design/des_round.sv
// ----------------------------------------------------------------------------
// des_round
// One registered Feistel round stage of the cipher pipeline.
// ----------------------------------------------------------------------------
module des_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  des_pkg::stage_ctl_type ctl_in,
   input  logic [31:0]           left_in,
   input  logic [31:0]           right_in,
   input  des_pkg::key_type      enc_key,
   input  des_pkg::key_type      dec_key,
   output des_pkg::stage_ctl_type ctl_out,
   output logic [31:0]           left_out,
   output logic [31:0]           right_out
);
   import des_pkg::*;

   stage_ctl_type ctl_ff;
   logic [31:0]   left_ff, left_in_next;
   logic [31:0]   right_ff, right_in_next;
   key_type       key_sel;

   always_comb begin
      key_sel       = ctl_in.decrypt ? dec_key : enc_key;
      left_in_next  = right_in;
      right_in_next = left_in ^ p_perm(sbox_layer(e_expand(right_in) ^ key_sel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   // Hold payload while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in_next;
         right_ff <= right_in_next;
      end
   end

   assign ctl_out   = ctl_ff;
   assign left_out  = left_ff;
   assign right_out = right_ff;

endmodule

FILE: design/des_block_cipher.sv
// ----------------------------------------------------------------------------
// des_block_cipher
// Pipelined DES core with a loadable sixteen-entry round key store.
// ----------------------------------------------------------------------------
// An encrypt or decrypt item runs through eighteen register stages: the
// initial permutation, sixteen Feistel rounds (one stage each) and the final
// permutation into the output register, and a new block may enter every
// cycle while the pipeline advances. The whole pipeline advances together; it
// freezes only while a result waits in the output register under rsp_stall.
// A load item writes its round key in the cycle it is accepted and yields no
// item on rsp_. Because every round stage reads the key store directly, a load
// is held off with req_stall until the pipeline holds no block. Operation 3 is
// accepted and dropped. Keys must be loaded before a block uses them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module des_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_key_index,
   input  logic [47:0] req_round_key,
   input  logic [63:0] req_data_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_block
);
   import des_pkg::*;

   logic           advance;
   logic           pipe_busy;
   logic           req_accept;
   logic           is_load;
   logic           is_block;
   key_bank_type   keys;

   // Stage 0 holds the block after the initial permutation.
   stage_ctl_type  ctl_ff [NumRounds+1];
   logic [31:0]    left_w [NumRounds+1];
   logic [31:0]    right_w [NumRounds+1];
   stage_ctl_type  ctl0_ff, ctl0_in;
   logic [63:0]    ip0_ff;
   logic           out_valid_ff;
   logic [63:0]    out_block_ff;
   logic [NumRounds:0] valid_vec;

   // Advance the whole pipeline unless a result is blocked at the output.
   assign advance = !(out_valid_ff && rsp_stall);

   always_comb begin
      for (int i = 0; i <= NumRounds; i++) begin
         valid_vec[i] = ctl_ff[i].valid;
      end
      pipe_busy = (|valid_vec) || out_valid_ff;
   end

   assign is_load   = (op_type'(req_operation) == OP_LOAD);
   assign is_block  = (op_type'(req_operation) == OP_ENCRYPT) ||
                      (op_type'(req_operation) == OP_DECRYPT);
   // Hold loads until no block is in flight.
   assign req_stall  = !advance || (is_load && pipe_busy);
   assign req_accept = req_valid && !req_stall;

   des_key_store u_keys (
      .clock       (clock),
      .write_en    (req_accept && is_load),
      .write_index (req_key_index),
      .write_key   (req_round_key),
      .keys        (keys)
   );

   always_comb begin
      ctl0_in.valid   = req_accept && is_block;
      ctl0_in.decrypt = (op_type'(req_operation) == OP_DECRYPT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (advance) begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ip0_ff <= ip_perm(req_data_block);
      end
   end

   assign ctl_ff[0]  = ctl0_ff;
   assign left_w[0]  = ip0_ff[63:32];
   assign right_w[0] = ip0_ff[31:0];

   // One round per stage; stage n uses key n, or key 15 - n to decrypt.
   for (genvar n = 0; n < NumRounds; n++) begin : g_round
      des_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_in    (ctl_ff[n]),
         .left_in   (left_w[n]),
         .right_in  (right_w[n]),
         .enc_key   (keys[n]),
         .dec_key   (keys[NumRounds-1-n]),
         .ctl_out   (ctl_ff[n+1]),
         .left_out  (left_w[n+1]),
         .right_out (right_w[n+1])
      );
   end

   // Final permutation of the swapped halves into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctl_ff[NumRounds].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_block_ff <= fp_perm({right_w[NumRounds], left_w[NumRounds]});
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_block = out_block_ff;

   `ASSERT_IMPLIES(a_load_only_when_empty, clock, reset, req_accept && is_load, !pipe_busy)
   `ASSERT_NEXT(a_block_enters_stage0, clock, reset, req_accept && is_block, ctl0_ff.valid)
   `ASSERT_NEXT(a_freeze_on_stall, clock, reset, out_valid_ff && rsp_stall, $stable(valid_vec))

endmodule
